// ===== hw/rtl/rpb_pkg.sv =====
// Shared types, register indexes and reset constants for the RC pulse to
// bridge PWM block. No dependencies.
`timescale 1ns / 1ps

package rpb_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int REG_W              = 16;
   localparam int CSR_ADDR_W         = 3;
   localparam int REQ_DATA_W         = 8;
   localparam int RSP_DATA_W         = 24;

   localparam logic [REG_W-1:0] PULSE_OFFSET_RST = 16'h00A0;
   localparam logic [REG_W-1:0] PWM_TOP_RST      = 16'h0125;
   localparam logic [REG_W-1:0] FORWARD_MIN_RST  = 16'd300;
   localparam logic [REG_W-1:0] REVERSE_LOW_RST  = 16'd100;
   localparam logic [REG_W-1:0] REVERSE_HIGH_RST = 16'd200;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PULSE_OFFSET = 3'd0,
      CSR_PWM_TOP      = 3'd1,
      CSR_FORWARD_MIN  = 3'd2,
      CSR_REVERSE_LOW  = 3'd3,
      CSR_REVERSE_HIGH = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [REG_W-1:0] pulse_offset;
      logic [REG_W-1:0] pwm_top;
      logic [REG_W-1:0] forward_min;
      logic [REG_W-1:0] reverse_low;
      logic [REG_W-1:0] reverse_high;
   } cfg_type;

   // Decoder outputs for the beat being accepted.
   typedef struct packed {
      logic             fwd_en;
      logic             rev_en;
      logic [REG_W-1:0] duty;
   } dec_type;

   // Result beat, last field in the lowest bit.
   typedef struct packed {
      logic [REG_W-1:0] duty_now;
      logic             rev_enabled;
      logic             fwd_enabled;
      logic             rev_out;
      logic             fwd_out;
   } rsp_type;

endpackage

// ===== hw/rtl/rc_pulse_to_bridge_pwm.sv =====
// RC pulse to bridge PWM top level: one input beat per cycle, one result beat each.
// A result enters the result buffer when its req beat is taken and leaves it on rsp.
// Throughput: one beat per cycle; a two-entry result buffer keeps req open until
// two results wait on rsp.
// Reset: synchronous; registers return to their reset values, both enables set.
// Depends on rpb_pkg, rpb_decode, rpb_pwm, rpb_out_buf.
`timescale 1ns / 1ps

module rc_pulse_to_bridge_pwm #(
   parameter int COUNT_BITS = rpb_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [0] dir_level, [1] speed_level
   input  logic [rpb_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] fwd_out, [1] rev_out, [2] fwd_enabled, [3] rev_enabled, [19:4] duty_now
   output logic [rpb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [rpb_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rpb_pkg::REG_W-1:0]      csr_wdata
);

   rpb_pkg::cfg_type          cfg_ff;
   rpb_pkg::dec_type          dec;
   rpb_pkg::rsp_type          rsp_new, rsp_head;
   logic                      accept;
   logic [rpb_pkg::REG_W-1:0] pwm_count;
   logic [1:0]                buf_level;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_offset <= rpb_pkg::PULSE_OFFSET_RST;
         cfg_ff.pwm_top      <= rpb_pkg::PWM_TOP_RST;
         cfg_ff.forward_min  <= rpb_pkg::FORWARD_MIN_RST;
         cfg_ff.reverse_low  <= rpb_pkg::REVERSE_LOW_RST;
         cfg_ff.reverse_high <= rpb_pkg::REVERSE_HIGH_RST;
      end else if (csr_we) begin
         case (csr_addr)
            rpb_pkg::CSR_PULSE_OFFSET: cfg_ff.pulse_offset <= csr_wdata;
            rpb_pkg::CSR_PWM_TOP:      cfg_ff.pwm_top      <= csr_wdata;
            rpb_pkg::CSR_FORWARD_MIN:  cfg_ff.forward_min  <= csr_wdata;
            rpb_pkg::CSR_REVERSE_LOW:  cfg_ff.reverse_low  <= csr_wdata;
            rpb_pkg::CSR_REVERSE_HIGH: cfg_ff.reverse_high <= csr_wdata;
            default: ;
         endcase
      end
   end

   rpb_decode #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .dir_level   (req_tdata[0]),
      .speed_level (req_tdata[1]),
      .cfg         (cfg_ff),
      .dec         (dec)
   );

   rpb_pwm u_pwm (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .pwm_top (cfg_ff.pwm_top),
      .dec     (dec),
      .rsp     (rsp_new),
      .count   (pwm_count)
   );

   rpb_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp_new),
      .has_room  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_head),
      .level     (buf_level)
   );

   assign rsp_tdata = {{(rpb_pkg::RSP_DATA_W - $bits(rpb_pkg::rsp_type)){1'b0}}, rsp_head};

   a_buf_level: assert property (@(posedge clock) disable iff (reset)
      buf_level != 2'd3)
      else $error("result buffer overfilled");

   a_full_valid: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("buffer full without a valid result");

   a_pwm_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && (pwm_count >= cfg_ff.pwm_top)) |=> (pwm_count == '0))
      else $error("pwm counter did not wrap at top");

   a_one_dir: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tdata[0] != $past(req_tdata[0])) && rsp_new.fwd_enabled)
         |-> !rsp_new.rev_enabled)
      else $error("both bridge directions chosen on a direction edge");

endmodule

// ===== hw/rtl/rpb_decode.sv =====
// Pulse width decoder: edge detect, width counters, bridge enables and duty.
// Depends on rpb_pkg.
`timescale 1ns / 1ps

module rpb_decode #(
   parameter int COUNT_BITS = rpb_pkg::COUNT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             dir_level,
   input  logic             speed_level,
   input  rpb_pkg::cfg_type cfg,
   output rpb_pkg::dec_type dec
);

   localparam int CMP_W = (COUNT_BITS > rpb_pkg::REG_W) ? COUNT_BITS : rpb_pkg::REG_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   logic                  prev_dir_ff, prev_dir_in;
   logic                  prev_speed_ff, prev_speed_in;
   logic                  dir_armed_ff, dir_armed_in;
   logic                  speed_armed_ff, speed_armed_in;
   logic [COUNT_BITS-1:0] dir_width_ff, dir_width_in;
   logic [COUNT_BITS-1:0] speed_width_ff, speed_width_in;
   logic                  fwd_en_ff, fwd_en_in;
   logic                  rev_en_ff, rev_en_in;
   logic [rpb_pkg::REG_W-1:0] duty_ff, duty_in;

   logic                  dir_edge, speed_edge;
   logic                  dir_arm_mid, speed_arm_mid;
   logic [COUNT_BITS-1:0] dir_w_mid, speed_w_mid;
   logic [CMP_W-1:0]      dir_w_ext, speed_w_ext;
   logic [CMP_W-1:0]      fmin_ext, rlow_ext, rhigh_ext, off_ext, top_ext;
   logic [CMP_W-1:0]      diff, clamped;

   always_comb begin
      dir_edge   = dir_level != prev_dir_ff;
      speed_edge = speed_level != prev_speed_ff;

      dir_w_ext   = CMP_W'(dir_width_ff);
      speed_w_ext = CMP_W'(speed_width_ff);
      fmin_ext    = CMP_W'(cfg.forward_min);
      rlow_ext    = CMP_W'(cfg.reverse_low);
      rhigh_ext   = CMP_W'(cfg.reverse_high);
      off_ext     = CMP_W'(cfg.pulse_offset);
      top_ext     = CMP_W'(cfg.pwm_top);

      fwd_en_in = fwd_en_ff;
      rev_en_in = rev_en_ff;
      if (dir_edge) begin
         fwd_en_in = dir_w_ext >= fmin_ext;
         rev_en_in = !(dir_w_ext >= fmin_ext) &&
                     (dir_w_ext >= rlow_ext) && (dir_w_ext <= rhigh_ext);
      end

      diff    = (speed_w_ext > off_ext) ? (speed_w_ext - off_ext) : '0;
      clamped = (diff > top_ext) ? top_ext : diff;
      duty_in = speed_edge ? rpb_pkg::REG_W'(clamped) : duty_ff;

      dir_arm_mid   = dir_edge ? 1'b1 : dir_armed_ff;
      dir_w_mid     = dir_edge ? '0 : dir_width_ff;
      speed_arm_mid = speed_edge ? 1'b1 : speed_armed_ff;
      speed_w_mid   = speed_edge ? '0 : speed_width_ff;

      dir_armed_in = dir_arm_mid;
      dir_width_in = dir_w_mid;
      if (dir_level && dir_arm_mid) begin
         if (dir_w_mid != CNT_MAX) dir_width_in = dir_w_mid + 1'b1;
      end else begin
         dir_armed_in = 1'b0;
      end

      speed_armed_in = speed_arm_mid;
      speed_width_in = speed_w_mid;
      if (speed_level && speed_arm_mid) begin
         if (speed_w_mid != CNT_MAX) speed_width_in = speed_w_mid + 1'b1;
      end else begin
         speed_armed_in = 1'b0;
      end

      prev_dir_in   = dir_level;
      prev_speed_in = speed_level;

      dec.fwd_en = fwd_en_in;
      dec.rev_en = rev_en_in;
      dec.duty   = duty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_dir_ff    <= 1'b0;
         prev_speed_ff  <= 1'b0;
         dir_armed_ff   <= 1'b0;
         speed_armed_ff <= 1'b0;
         dir_width_ff   <= '0;
         speed_width_ff <= '0;
         fwd_en_ff      <= 1'b1;
         rev_en_ff      <= 1'b1;
         duty_ff        <= '0;
      end else if (accept) begin
         prev_dir_ff    <= prev_dir_in;
         prev_speed_ff  <= prev_speed_in;
         dir_armed_ff   <= dir_armed_in;
         speed_armed_ff <= speed_armed_in;
         dir_width_ff   <= dir_width_in;
         speed_width_ff <= speed_width_in;
         fwd_en_ff      <= fwd_en_in;
         rev_en_ff      <= rev_en_in;
         duty_ff        <= duty_in;
      end
   end

endmodule

// ===== hw/rtl/rpb_pwm.sv =====
// Fast PWM counter and bridge output compare.
// Depends on rpb_pkg.
`timescale 1ns / 1ps

module rpb_pwm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [rpb_pkg::REG_W-1:0] pwm_top,
   input  rpb_pkg::dec_type          dec,
   output rpb_pkg::rsp_type          rsp,
   output logic [rpb_pkg::REG_W-1:0] count
);

   logic [rpb_pkg::REG_W-1:0] count_ff, count_in;
   logic                      below;

   always_comb begin
      below           = count_ff < dec.duty;
      rsp.fwd_out     = dec.fwd_en && below;
      rsp.rev_out     = dec.rev_en && below;
      rsp.fwd_enabled = dec.fwd_en;
      rsp.rev_enabled = dec.rev_en;
      rsp.duty_now    = dec.duty;
      count_in        = (count_ff >= pwm_top) ? '0 : count_ff + 1'b1;
   end

   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/rpb_out_buf.sv =====
// Two-entry result buffer between the PWM compare and the rsp channel.
// Depends on rpb_pkg.
`timescale 1ns / 1ps

module rpb_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rpb_pkg::rsp_type push_data,
   output logic             has_room,
   output logic             out_valid,
   input  logic             out_ready,
   output rpb_pkg::rsp_type out_data,
   output logic [1:0]       level
);

   rpb_pkg::rsp_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             pop;

   always_comb begin
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign has_room  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign level     = cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for rc_pulse_to_bridge_pwm: pulse trains on both receiver
// channels go through the stream ports; each result beat is checked against a
// drill row or a local decoder and PWM model. Depends on rpb_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

   localparam int TICK_W         = rpb_pkg::COUNT_BITS_DEFAULT;
   localparam int QUIET_LIMIT    = 2000;
   localparam int RX_HOLD_CYCLES = 80;
   localparam int DRILL_N        = 26;

   typedef struct packed {
      logic                      dir_lvl;
      logic                      spd_lvl;
      logic                      typed;
      logic                      fwd_out;
      logic                      rev_out;
      logic                      fwd_en;
      logic                      rev_en;
      logic [rpb_pkg::REG_W-1:0] duty;
   } drill_row_type;

   // Widths for the drill: offset 1, top 3, forward at 6, reverse 2..4.
   localparam rpb_pkg::cfg_type DRILL_CFG = '{16'd1, 16'd3, 16'd6, 16'd2, 16'd4};

   localparam drill_row_type DRILL_ROWS [DRILL_N] = '{
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 16'd0},
      '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}
   };

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [rpb_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [rpb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_we;
   logic [rpb_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [rpb_pkg::REG_W-1:0]      csr_wdata;

   rc_pulse_to_bridge_pwm #(.COUNT_BITS(TICK_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Local copy of the decoder and PWM state.
   rpb_pkg::cfg_type          bridge_cfg;
   logic                      seen_dir;
   logic                      seen_speed;
   logic                      dir_live;
   logic                      speed_live;
   logic [TICK_W-1:0]         dir_ticks;
   logic [TICK_W-1:0]         speed_ticks;
   logic                      fwd_on;
   logic                      rev_on;
   logic [rpb_pkg::REG_W-1:0] duty_cmp;
   logic [rpb_pkg::REG_W-1:0] pwm_phase;

   rpb_pkg::rsp_type bridge_beats_due [$];

   int   send_idle_pct;
   int   recv_idle_pct;
   bit   stall_request;
   int   mismatch_count;
   int   quiet_cycles;
   logic gen_dir;
   logic gen_spd;
   int   gen_dir_left;
   int   gen_spd_left;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic rpb_pkg::rsp_type predict_bridge_beat(input logic dir_lvl,
                                                            input logic spd_lvl);
      rpb_pkg::rsp_type  beat;
      logic [TICK_W-1:0] duty_next;
      if (dir_lvl != seen_dir) begin
         dir_live = 1'b1;
         fwd_on   = 1'b0;
         rev_on   = 1'b0;
         if (dir_ticks >= bridge_cfg.forward_min) begin
            fwd_on = 1'b1;
         end else if (dir_ticks >= bridge_cfg.reverse_low &&
                      dir_ticks <= bridge_cfg.reverse_high) begin
            rev_on = 1'b1;
         end
         dir_ticks = '0;
      end
      if (spd_lvl != seen_speed) begin
         speed_live = 1'b1;
         duty_next  = (speed_ticks > bridge_cfg.pulse_offset) ?
                      speed_ticks - bridge_cfg.pulse_offset : '0;
         if (duty_next > bridge_cfg.pwm_top) duty_next = bridge_cfg.pwm_top;
         duty_cmp    = duty_next[rpb_pkg::REG_W-1:0];
         speed_ticks = '0;
      end
      seen_dir   = dir_lvl;
      seen_speed = spd_lvl;
      if (spd_lvl && speed_live) begin
         if (speed_ticks != '1) speed_ticks = speed_ticks + 1'b1;
      end else begin
         speed_live = 1'b0;
      end
      if (dir_lvl && dir_live) begin
         if (dir_ticks != '1) dir_ticks = dir_ticks + 1'b1;
      end else begin
         dir_live = 1'b0;
      end
      beat.fwd_out     = fwd_on && (pwm_phase < duty_cmp);
      beat.rev_out     = rev_on && (pwm_phase < duty_cmp);
      beat.fwd_enabled = fwd_on;
      beat.rev_enabled = rev_on;
      beat.duty_now    = duty_cmp;
      pwm_phase = (pwm_phase >= bridge_cfg.pwm_top) ? '0 : pwm_phase + 1'b1;
      return beat;
   endfunction

   function automatic rpb_pkg::cfg_type random_cfg();
      rpb_pkg::cfg_type c;
      c.pulse_offset = 16'($urandom_range(12));
      c.pwm_top      = 16'($urandom_range(24, 1));
      c.forward_min  = 16'($urandom_range(30));
      c.reverse_low  = 16'($urandom_range(20));
      c.reverse_high = 16'($urandom_range(30));
      return c;
   endfunction

   // Favor level durations that land on or next to a decision threshold.
   function automatic int pick_hold(input rpb_pkg::cfg_type c, input int span);
      int marks [5];
      int pick;
      marks[0] = int'(c.forward_min);
      marks[1] = int'(c.reverse_low);
      marks[2] = int'(c.reverse_high);
      marks[3] = int'(c.pulse_offset) + int'(c.pwm_top);
      marks[4] = int'(c.pulse_offset);
      pick = marks[$urandom_range(4)] + int'($urandom_range(2)) - 1;
      if ($urandom_range(1) == 0 || pick < 1 || pick > span) pick = $urandom_range(span, 1);
      return pick;
   endfunction

   task automatic send_tick(input logic dir_lvl, input logic spd_lvl,
                            input logic use_want, input rpb_pkg::rsp_type want);
      rpb_pkg::rsp_type beat;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(rpb_pkg::REQ_DATA_W-2){1'b0}}, spd_lvl, dir_lvl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beat = predict_bridge_beat(dir_lvl, spd_lvl);
      bridge_beats_due.push_back(use_want ? want : beat);
   endtask

   task automatic wait_bridge_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (bridge_beats_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rpb_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [rpb_pkg::REG_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= val;
      case (addr)
         rpb_pkg::CSR_PULSE_OFFSET: bridge_cfg.pulse_offset = val;
         rpb_pkg::CSR_PWM_TOP:      bridge_cfg.pwm_top      = val;
         rpb_pkg::CSR_FORWARD_MIN:  bridge_cfg.forward_min  = val;
         rpb_pkg::CSR_REVERSE_LOW:  bridge_cfg.reverse_low  = val;
         rpb_pkg::CSR_REVERSE_HIGH: bridge_cfg.reverse_high = val;
         default: ;
      endcase
   endtask

   task automatic end_csr_burst();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_cfg(input rpb_pkg::cfg_type c);
      write_reg(rpb_pkg::CSR_PULSE_OFFSET, c.pulse_offset);
      write_reg(rpb_pkg::CSR_PWM_TOP, c.pwm_top);
      write_reg(rpb_pkg::CSR_FORWARD_MIN, c.forward_min);
      write_reg(rpb_pkg::CSR_REVERSE_LOW, c.reverse_low);
      write_reg(rpb_pkg::CSR_REVERSE_HIGH, c.reverse_high);
      end_csr_burst();
   endtask

   // Mostly well-formed pulse trains on both channels, with some noise.
   task automatic run_phase(input rpb_pkg::cfg_type c, input int span, input int beats,
                            input bit hold_rsp);
      logic d;
      logic s;
      write_cfg(c);
      if (hold_rsp) stall_request = 1'b1;
      for (int k = 0; k < beats; k++) begin
         if ($urandom_range(9) == 0) begin
            d = 1'($urandom_range(1));
            s = 1'($urandom_range(1));
         end else begin
            if (gen_dir_left <= 0) begin
               gen_dir      = ~gen_dir;
               gen_dir_left = pick_hold(c, span);
            end
            if (gen_spd_left <= 0) begin
               gen_spd      = ~gen_spd;
               gen_spd_left = pick_hold(c, span);
            end
            d = gen_dir;
            s = gen_spd;
            gen_dir_left--;
            gen_spd_left--;
         end
         send_tick(d, s, 1'b0, '0);
      end
      wait_bridge_idle();
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rpb_pkg::rsp_type got;
      rpb_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rpb_pkg::rsp_type'(rsp_tdata[$bits(rpb_pkg::rsp_type)-1:0]);
         if (bridge_beats_due.size() == 0) begin
            $error("unexpected result beat: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = bridge_beats_due.pop_front();
            check_field("fwd_out", want.fwd_out, got.fwd_out);
            check_field("rev_out", want.rev_out, got.rev_out);
            check_field("fwd_enabled", want.fwd_enabled, got.fwd_enabled);
            check_field("rev_enabled", want.rev_enabled, got.rev_enabled);
            check_field("duty_now", want.duty_now, got.duty_now);
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            rsp_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(negedge clock);
            stall_request = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("rc_pulse_to_bridge_pwm verification failed");
         $finish;
      end
   end

   initial begin
      rpb_pkg::rsp_type want;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_we         = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      stall_request  = 1'b0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      gen_dir        = 1'b0;
      gen_spd        = 1'b0;
      gen_dir_left   = 0;
      gen_spd_left   = 0;
      bridge_cfg     = '{rpb_pkg::PULSE_OFFSET_RST, rpb_pkg::PWM_TOP_RST,
                         rpb_pkg::FORWARD_MIN_RST, rpb_pkg::REVERSE_LOW_RST,
                         rpb_pkg::REVERSE_HIGH_RST};
      seen_dir       = 1'b0;
      seen_speed     = 1'b0;
      dir_live       = 1'b0;
      speed_live     = 1'b0;
      dir_ticks      = '0;
      speed_ticks    = '0;
      fwd_on         = 1'b1;
      rev_on         = 1'b1;
      duty_cmp       = '0;
      pwm_phase      = '0;
      send_idle_pct  = 35;
      recv_idle_pct  = 54;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_cfg(DRILL_CFG);
      for (int r = 0; r < DRILL_N; r++) begin
         want.fwd_out     = DRILL_ROWS[r].fwd_out;
         want.rev_out     = DRILL_ROWS[r].rev_out;
         want.fwd_enabled = DRILL_ROWS[r].fwd_en;
         want.rev_enabled = DRILL_ROWS[r].rev_en;
         want.duty_now    = DRILL_ROWS[r].duty;
         send_tick(DRILL_ROWS[r].dir_lvl, DRILL_ROWS[r].spd_lvl, DRILL_ROWS[r].typed, want);
      end
      wait_bridge_idle();

      run_phase('{16'd3, 16'd9, 16'd12, 16'd4, 16'd8}, 24, 180, 1'b0);
      // zero top: counter and duty pinned at zero
      run_phase('{16'd2, 16'd0, 16'd5, 16'd1, 16'd3}, 12, 150, 1'b0);
      write_cfg('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF});
      // unmapped indexes must not disturb any register
      for (int a = int'(rpb_pkg::CSR_REVERSE_HIGH) + 1; a < (1 << rpb_pkg::CSR_ADDR_W);
           a++) begin
         write_reg(a[rpb_pkg::CSR_ADDR_W-1:0], (a % 2 == 0) ? 16'h0000 : 16'hFFFF);
      end
      end_csr_burst();
      run_phase('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF}, 30, 120, 1'b0);

      send_idle_pct = 54;
      recv_idle_pct = 35;
      run_phase('{16'd5, 16'd20, 16'd0, 16'd0, 16'd0}, 30, 180, 1'b0);
      // lower top below the running counter
      run_phase('{16'd1, 16'd3, 16'd20, 16'd6, 16'd15}, 30, 180, 1'b0);
      run_phase('{rpb_pkg::PULSE_OFFSET_RST, rpb_pkg::PWM_TOP_RST,
                  rpb_pkg::FORWARD_MIN_RST, rpb_pkg::REVERSE_LOW_RST,
                  rpb_pkg::REVERSE_HIGH_RST}, 360, 300, 1'b0);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(random_cfg(), 30, 180, 1'b1);

      run_phase(random_cfg(), 30, 200, 1'b0);
      run_phase('{16'd0, 16'd1, 16'd0, 16'd0, 16'd0}, 8, 100, 1'b0);

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && bridge_beats_due.size() == 0) begin
         $display("rc_pulse_to_bridge_pwm verification clean");
      end else begin
         $display("rc_pulse_to_bridge_pwm verification failed");
      end
      $finish;
   end

endmodule
